FILE: design/operand_forwarding_stage_register_defines.svh
// Assertion macros shared by the operand forwarding stage register modules.
`ifndef OPERAND_FORWARDING_STAGE_REGISTER_DEFINES_SVH
`define OPERAND_FORWARDING_STAGE_REGISTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OFSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define OFSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ofsr_pkg.sv
// Types and codes shared by the operand forwarding stage register modules.
package ofsr_pkg;

  localparam int unsigned RegW  = 5;
  localparam int unsigned DataW = 32;

  // Control code carried with each item.
  typedef enum logic [1:0] {
    FUNC_ADVANCE = 2'd0,
    FUNC_BUBBLE  = 2'd1,
    FUNC_PAUSE   = 2'd2,
    FUNC_FLUSH   = 2'd3
  } func_t;

  // Destination and result of one later pipeline stage.
  typedef struct packed {
    logic [RegW-1:0]  dest;
    logic [DataW-1:0] value;
  } stage_t;

  // What one forwarding lane found for its source.
  typedef struct packed {
    logic [DataW-1:0] value;
    logic             hazard;
  } lane_res_t;

  // Content of the decode-to-execute register.
  typedef struct packed {
    logic             op_valid;
    logic [RegW-1:0]  src_a;
    logic [RegW-1:0]  src_b;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic             hazard;
  } held_t;

endpackage

FILE: design/operand_forwarding_stage_register.sv
// Top level: decode-to-execute register with operand bypass, stream in and out.
//
// Usage:
//   Slave channel s_* carries one item per instruction slot: tuser is the
//   control code (advance, bubble, pause, flush), tdata the source register
//   numbers, register file values and the EX/MEM/WB destinations and results.
//   Master channel m_* returns one item per accepted input: the register
//   content after that update (tuser = op_valid, tdata = sources, operands,
//   load hazard flag).
//   Two forwarding lanes, one per source, resolve the bypass in parallel;
//   the merge stage applies the control code and updates the held register.
// Each result is registered in the output register, or in the skid entry while
//   the receiver stalls. Throughput: one item per cycle while s_tready is high;
//   the limit is the held register, updated by each item from the previous one.
// Reset (rst, synchronous): held register cleared to zero, output and skid
//   entries emptied.
// Receiver stall: the output register holds its item and a skid entry takes
//   one more; only with both full does s_tready drop. No item is lost.
module operand_forwarding_stage_register (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata from bit 0: src_a_reg[4:0], src_b_reg[9:5], file_val_a[41:10],
  // file_val_b[73:42], exec_dest[78:74], exec_value[110:79],
  // exec_is_load[111], mem_dest[116:112], mem_value[148:117],
  // back_dest[153:149], back_value[185:154], zero pad[191:186]
  input  logic [191:0] s_tdata,
  // s_tuser: func[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata from bit 0: out_src_a[4:0], out_src_b[9:5], operand_a[41:10],
  // operand_b[73:42], load_hazard[74], zero pad[79:75]
  output logic [79:0]  m_tdata,
  // m_tuser: op_valid
  output logic         m_tuser
);

  logic                       accept;
  ofsr_pkg::func_t            func;
  logic [ofsr_pkg::RegW-1:0]  src_a_reg;
  logic [ofsr_pkg::RegW-1:0]  src_b_reg;
  logic [ofsr_pkg::DataW-1:0] file_val_a;
  logic [ofsr_pkg::DataW-1:0] file_val_b;
  ofsr_pkg::stage_t           exec_stage;
  logic                       exec_is_load;
  ofsr_pkg::stage_t           mem_stage;
  ofsr_pkg::stage_t           back_stage;
  ofsr_pkg::lane_res_t        lane_a;
  ofsr_pkg::lane_res_t        lane_b;
  ofsr_pkg::held_t            held_next;
  ofsr_pkg::held_t            out_item;

  // Unpack the input item.
  assign func             = ofsr_pkg::func_t'(s_tuser);
  assign src_a_reg        = s_tdata[4:0];
  assign src_b_reg        = s_tdata[9:5];
  assign file_val_a       = s_tdata[41:10];
  assign file_val_b       = s_tdata[73:42];
  assign exec_stage.dest  = s_tdata[78:74];
  assign exec_stage.value = s_tdata[110:79];
  assign exec_is_load     = s_tdata[111];
  assign mem_stage.dest   = s_tdata[116:112];
  assign mem_stage.value  = s_tdata[148:117];
  assign back_stage.dest  = s_tdata[153:149];
  assign back_stage.value = s_tdata[185:154];

  assign accept = s_tvalid && s_tready;

  // Lane per source operand.
  ofsr_lane u_lane_a (
    .src          (src_a_reg),
    .file_val     (file_val_a),
    .exec_stage   (exec_stage),
    .exec_is_load (exec_is_load),
    .mem_stage    (mem_stage),
    .back_stage   (back_stage),
    .res          (lane_a)
  );

  ofsr_lane u_lane_b (
    .src          (src_b_reg),
    .file_val     (file_val_b),
    .exec_stage   (exec_stage),
    .exec_is_load (exec_is_load),
    .mem_stage    (mem_stage),
    .back_stage   (back_stage),
    .res          (lane_b)
  );

  // Held register; held_next is the content this item reports.
  ofsr_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .func      (func),
    .src_a     (src_a_reg),
    .src_b     (src_b_reg),
    .lane_a    (lane_a),
    .lane_b    (lane_b),
    .held_next (held_next)
  );

  ofsr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (held_next),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_item)
  );

  assign m_tuser = out_item.op_valid;
  assign m_tdata = {5'b0, out_item.hazard, out_item.operand_b, out_item.operand_a,
                    out_item.src_b, out_item.src_a};

endmodule

FILE: design/ofsr_lane.sv
// One forwarding lane: picks the operand for a single source register.
module ofsr_lane (
  input  logic [ofsr_pkg::RegW-1:0]  src,
  input  logic [ofsr_pkg::DataW-1:0] file_val,
  input  ofsr_pkg::stage_t           exec_stage,
  input  logic                       exec_is_load,
  input  ofsr_pkg::stage_t           mem_stage,
  input  ofsr_pkg::stage_t           back_stage,
  output ofsr_pkg::lane_res_t        res
);

  // Youngest matching stage wins; x0 never forwards.
  always_comb begin
    res.hazard = 1'b0;
    priority if (src == '0) begin
      res.value = '0;
    end else if (exec_stage.dest == src) begin
      res.value  = exec_stage.value;
      res.hazard = exec_is_load;
    end else if (mem_stage.dest == src) begin
      res.value = mem_stage.value;
    end else if (back_stage.dest == src) begin
      res.value = back_stage.value;
    end else begin
      res.value = file_val;
    end
  end

endmodule

FILE: design/ofsr_merge.sv
// Merge stage: combines both lanes under the control code into the held register.
`include "operand_forwarding_stage_register_defines.svh"

module ofsr_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  ofsr_pkg::func_t           func,
  input  logic [ofsr_pkg::RegW-1:0] src_a,
  input  logic [ofsr_pkg::RegW-1:0] src_b,
  input  ofsr_pkg::lane_res_t       lane_a,
  input  ofsr_pkg::lane_res_t       lane_b,
  output ofsr_pkg::held_t           held_next
);

  ofsr_pkg::held_t held;

  always_comb begin
    held_next = held;
    unique case (func)
      ofsr_pkg::FUNC_ADVANCE: begin
        held_next.op_valid  = 1'b1;
        held_next.src_a     = src_a;
        held_next.src_b     = src_b;
        held_next.operand_a = lane_a.value;
        held_next.operand_b = lane_b.value;
        held_next.hazard    = lane_a.hazard | lane_b.hazard;
      end
      ofsr_pkg::FUNC_BUBBLE: begin
        held_next.op_valid  = 1'b0;
        held_next.src_a     = src_a;
        held_next.src_b     = src_b;
        held_next.operand_a = '0;
        held_next.operand_b = '0;
        held_next.hazard    = 1'b0;
      end
      ofsr_pkg::FUNC_PAUSE: begin
        held_next = held;
      end
      ofsr_pkg::FUNC_FLUSH: begin
        held_next = '0;
      end
      default: begin
        held_next = held;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept) begin
      held <= held_next;
    end
  end

  `OFSR_ASSERT_NEXT(a_flush_clears, accept && func == ofsr_pkg::FUNC_FLUSH, held == '0, "flush left state behind")
  `OFSR_ASSERT_NEXT(a_bubble_zero, accept && func == ofsr_pkg::FUNC_BUBBLE, !held.op_valid && held.operand_a == '0 && held.operand_b == '0 && !held.hazard, "bubble not zeroed")
  `OFSR_ASSERT_NOW(a_hazard_valid, held.hazard, held.op_valid, "hazard flag on an invalid op")

endmodule

FILE: design/ofsr_skid.sv
// Output register with one skid entry, so input and output stall independently.
`include "operand_forwarding_stage_register_defines.svh"

module ofsr_skid (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ofsr_pkg::held_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ofsr_pkg::held_t out_data
);

  logic            skid_valid;
  ofsr_pkg::held_t skid_data;
  logic            out_take;
  logic            in_take;

  assign in_ready = !skid_valid;
  assign out_take = out_valid && out_ready;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!in_take) begin
        out_valid <= 1'b0;
      end
    end else if (in_take) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload, no reset.
  always_ff @(posedge clk) begin
    if (out_take && skid_valid) begin
      out_data <= skid_data;
    end else if (in_take && (out_take || !out_valid)) begin
      out_data <= in_data;
    end
    if (in_take && out_valid && !out_take) begin
      skid_data <= in_data;
    end
  end

  `OFSR_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid entry without output entry")

endmodule

FILE: dv/tb.sv
// Testbench for operand_forwarding_stage_register: stream stimulus, bypass predictor, checks.
module tb;
  import ofsr_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  // One decoded instruction slot as offered on the slave channel.
  typedef struct {
    func_t             func;
    logic [RegW-1:0]   src_a;
    logic [RegW-1:0]   src_b;
    logic [DataW-1:0]  file_a;
    logic [DataW-1:0]  file_b;
    stage_t            ex;
    logic              ex_load;
    stage_t            mem;
    stage_t            wb;
  } slot_t;

  // Tracks the decode/execute register and the queue of register contents
  // still owed on the master channel.
  class bypass_scoreboard;
    held_t held = '0;
    held_t expected_regs[$];
    int    fails = 0;

    // EX beats MEM beats WB; register 0 never forwards.
    function logic [DataW-1:0] forward_operand(logic [RegW-1:0] src,
                                               logic [DataW-1:0] file_val,
                                               slot_t s, inout logic hz);
      if (src == '0) return '0;
      if (s.ex.dest == src) begin
        if (s.ex_load) hz = 1'b1;
        return s.ex.value;
      end
      if (s.mem.dest == src) return s.mem.value;
      if (s.wb.dest == src) return s.wb.value;
      return file_val;
    endfunction

    function void note_issue(slot_t s);
      logic hz;
      hz = 1'b0;
      case (s.func)
        FUNC_FLUSH: held = '0;
        FUNC_BUBBLE: begin
          held = '0;
          held.src_a = s.src_a;
          held.src_b = s.src_b;
        end
        FUNC_ADVANCE: begin
          held.operand_a = forward_operand(s.src_a, s.file_a, s, hz);
          held.operand_b = forward_operand(s.src_b, s.file_b, s, hz);
          held.op_valid  = 1'b1;
          held.src_a     = s.src_a;
          held.src_b     = s.src_b;
          held.hazard    = hz;
        end
        default: ; // pause: content kept, reported again
      endcase
      expected_regs.push_back(held);
    endfunction

    function void compare(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_latched(logic [79:0] tdata, logic tuser);
      held_t want;
      if (expected_regs.size() == 0) begin
        $error("result with nothing expected: tdata %0h tuser %0b", tdata, tuser);
        fails++;
        return;
      end
      want = expected_regs.pop_front();
      compare("op_valid", DataW'(want.op_valid), DataW'(tuser));
      compare("out_src_a", DataW'(want.src_a), DataW'(tdata[4:0]));
      compare("out_src_b", DataW'(want.src_b), DataW'(tdata[9:5]));
      compare("operand_a", want.operand_a, tdata[41:10]);
      compare("operand_b", want.operand_b, tdata[73:42]);
      compare("load_hazard", DataW'(want.hazard), DataW'(tdata[74]));
    endfunction

    function int pending();
      return expected_regs.size();
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [191:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [79:0]  m_tdata;
  logic         m_tuser;

  bypass_scoreboard sb;
  bit  tx_calm;
  bit  rx_calm;
  int  cycles;

  operand_forwarding_stage_register u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on total run length.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Output monitor: pre-edge values sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_latched(m_tdata, m_tuser);
  end

  // Receiver back-pressure: mostly short stalls, now and then a long one.
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_calm) begin
        m_tready = 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if ($urandom_range(0, 59) == 0) stall_left = $urandom_range(10, 40);
        else if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
      end
      @(negedge clk);
    end
  end

  function automatic slot_t mk(func_t f, logic [4:0] sa, logic [4:0] sb_reg,
                               logic [31:0] fa, logic [31:0] fb,
                               logic [4:0] exd, logic [31:0] exv, logic exl,
                               logic [4:0] md, logic [31:0] mv,
                               logic [4:0] wd, logic [31:0] wv);
    slot_t s;
    s.func = f;
    s.src_a = sa;
    s.src_b = sb_reg;
    s.file_a = fa;
    s.file_b = fb;
    s.ex.dest = exd;
    s.ex.value = exv;
    s.ex_load = exl;
    s.mem.dest = md;
    s.mem.value = mv;
    s.wb.dest = wd;
    s.wb.value = wv;
    return s;
  endfunction

  // Source numbers drawn from a small pool so stage destinations collide often.
  function automatic logic [4:0] pick_src();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 6) return 5'($urandom_range(1, 4));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [4:0] pick_dest(logic [4:0] sa, logic [4:0] sb_reg);
    int r;
    r = $urandom_range(0, 7);
    if (r < 3) return sa;
    if (r < 5) return sb_reg;
    if (r == 5) return '0;
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic slot_t rand_slot();
    slot_t s;
    int    r;
    r = $urandom_range(0, 19);
    if (r < 12) s.func = FUNC_ADVANCE;
    else if (r < 15) s.func = FUNC_BUBBLE;
    else if (r < 18) s.func = FUNC_PAUSE;
    else s.func = FUNC_FLUSH;
    s.src_a = pick_src();
    s.src_b = pick_src();
    s.file_a = $urandom;
    s.file_b = $urandom;
    s.ex.dest = pick_dest(s.src_a, s.src_b);
    s.ex.value = $urandom;
    s.ex_load = $urandom_range(0, 2) == 0;
    s.mem.dest = pick_dest(s.src_a, s.src_b);
    s.mem.value = $urandom;
    s.wb.dest = pick_dest(s.src_a, s.src_b);
    s.wb.value = $urandom;
    return s;
  endfunction

  // Entered and left at a falling edge; s_tvalid is written once per edge.
  task automatic send_slot(slot_t s);
    int gap;
    int r;
    gap = 0;
    if (!tx_calm) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(8, 30);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = s.func;
    s_tdata  = {6'b0, s.wb.value, s.wb.dest, s.mem.value, s.mem.dest, s.ex_load,
                s.ex.value, s.ex.dest, s.file_b, s.file_a, s.src_b, s.src_a};
    forever begin
      @(posedge clk);
      if (s_tready) break;
      @(negedge clk);
    end
    sb.note_issue(s);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    sb = new();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = FUNC_ADVANCE;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed: zero sources, priority order, load hazards, every control code.
    send_slot(mk(FUNC_PAUSE, 5'd3, 5'd4, '1, '1, 5'd3, '1, 1'b1, 5'd4, '1, 5'd3, '1));
    send_slot(mk(FUNC_ADVANCE, 5'd0, 5'd0, '1, '1, 5'd0, '1, 1'b1, 5'd0, '1, 5'd0, '1));
    send_slot(mk(FUNC_ADVANCE, 5'd31, 5'd31, '1, '1, 5'd1, '0, 1'b0, 5'd2, '0, 5'd3, '0));
    send_slot(mk(FUNC_ADVANCE, 5'd31, 5'd30, '0, '0, 5'd30, '1, 1'b0, 5'd31, '1, 5'd0, '1));
    send_slot(mk(FUNC_ADVANCE, 5'd7, 5'd7, 32'h1, 32'h2, 5'd7, 32'hAAAA5555, 1'b0,
                 5'd7, 32'h12345678, 5'd7, 32'h9ABCDEF0));
    send_slot(mk(FUNC_ADVANCE, 5'd9, 5'd10, 32'h1, 32'h2, 5'd1, 32'h3, 1'b0,
                 5'd9, 32'h5555AAAA, 5'd9, 32'hDEADBEEF));
    send_slot(mk(FUNC_ADVANCE, 5'd12, 5'd13, 32'h1, 32'h2, 5'd1, 32'h3, 1'b0,
                 5'd2, 32'h4, 5'd13, 32'hFFFF0000));
    send_slot(mk(FUNC_ADVANCE, 5'd5, 5'd6, 32'h11, 32'h22, 5'd5, 32'hCAFE0001, 1'b1,
                 5'd6, 32'h33, 5'd0, 32'h44));
    send_slot(mk(FUNC_ADVANCE, 5'd5, 5'd6, 32'h11, 32'h22, 5'd6, 32'hCAFE0002, 1'b1,
                 5'd5, 32'h33, 5'd5, 32'h44));
    send_slot(mk(FUNC_ADVANCE, 5'd5, 5'd6, 32'h11, 32'h22, 5'd7, 32'hCAFE0003, 1'b1,
                 5'd0, 32'h33, 5'd0, 32'h44));
    send_slot(mk(FUNC_ADVANCE, 5'd8, 5'd8, '0, '1, 5'd8, '1, 1'b1, 5'd8, '0, 5'd8, '0));
    send_slot(mk(FUNC_ADVANCE, 5'd0, 5'd8, '1, '0, 5'd0, '1, 1'b1, 5'd0, '1, 5'd0, '1));
    send_slot(mk(FUNC_PAUSE, 5'd1, 5'd2, '0, '0, 5'd1, '0, 1'b1, 5'd2, '0, 5'd1, '0));
    send_slot(mk(FUNC_PAUSE, 5'd0, 5'd0, '1, '1, 5'd0, '1, 1'b0, 5'd0, '1, 5'd0, '1));
    send_slot(mk(FUNC_BUBBLE, 5'd31, 5'd17, '1, '1, 5'd31, '1, 1'b1, 5'd17, '1, 5'd31, '1));
    send_slot(mk(FUNC_PAUSE, 5'd2, 5'd3, '0, '0, 5'd2, '0, 1'b0, 5'd3, '0, 5'd2, '0));
    send_slot(mk(FUNC_ADVANCE, 5'd21, 5'd10, '1, '1, 5'd10, 32'h0F0F0F0F, 1'b0,
                 5'd21, 32'hF0F0F0F0, 5'd0, '0));
    send_slot(mk(FUNC_FLUSH, 5'd31, 5'd31, '1, '1, 5'd31, '1, 1'b1, 5'd31, '1, 5'd31, '1));
    send_slot(mk(FUNC_PAUSE, 5'd31, 5'd31, '1, '1, 5'd31, '1, 1'b1, 5'd31, '1, 5'd31, '1));
    send_slot(mk(FUNC_ADVANCE, 5'd16, 5'd15, '1, '1, 5'd0, '1, 1'b1, 5'd0, '1, 5'd0, '1));

    // Random with gaps and stalls on both sides.
    repeat (200) send_slot(rand_slot());

    // Hold the sender until the pipeline is empty.
    drain();

    // A stretch with no idling at all.
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (120) send_slot(rand_slot());
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    repeat (310) send_slot(rand_slot());

    drain();
    repeat (4) @(negedge clk);
    if (sb.fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/ofsr_pkg.sv
design/ofsr_lane.sv
design/ofsr_merge.sv
design/ofsr_skid.sv
design/operand_forwarding_stage_register.sv
dv/tb.sv
